[hw/rtl/lgp_pkg.sv]
package lgp_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int GROUP_BITS  = 16;
	localparam int HASH_BITS   = 32;
	localparam int KIND_BITS   = 2;
	localparam int MAX_RESULTS = 3;
	localparam int NUM_BITS    = $clog2(MAX_RESULTS + 1);

	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = $clog2(QDEPTH);
	localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

	localparam logic [HASH_BITS-1:0] FNV_START = 32'h811C_9DC5;
	localparam logic [HASH_BITS-1:0] FNV_PRIME = 32'h0100_0193;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_NAME  = 2'd0,
		KIND_GROUP = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [OFFSET_BITS-1:0] line_start;
		logic [OFFSET_BITS-1:0] line_length;
		logic [GROUP_BITS-1:0]  group_size;
		logic [HASH_BITS-1:0]   text_hash;
		logic [OFFSET_BITS-1:0] byte_total;
		logic                   run_last;
	} res_t;

	typedef struct packed {
		logic [NUM_BITS-1:0]    num;
		res_t [MAX_RESULTS-1:0] item;
	} push_t;

	function automatic logic [OFFSET_BITS-1:0] sat_off(input logic [OFFSET_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [GROUP_BITS-1:0] sat_grp(input logic [GROUP_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CHAR_SPACE) || (b == CHAR_TAB);
	endfunction

endpackage

[hw/rtl/lgp_if.sv]
interface lgp_in_if import lgp_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] data_byte;

	modport source (output valid, output cmd, output data_byte, input ready);
	modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface lgp_out_if import lgp_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [KIND_BITS-1:0]   kind;
	logic [OFFSET_BITS-1:0] line_start;
	logic [OFFSET_BITS-1:0] line_length;
	logic [GROUP_BITS-1:0]  group_size;
	logic [HASH_BITS-1:0]   text_hash;
	logic [OFFSET_BITS-1:0] byte_total;
	logic                   run_last;

	modport source (output valid, output kind, output line_start, output line_length,
		output group_size, output text_hash, output byte_total, output run_last,
		input ready);
	modport sink (input valid, input kind, input line_start, input line_length,
		input group_size, input text_hash, input byte_total, input run_last,
		output ready);
endinterface

interface lgp_cfg_if import lgp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [HASH_BITS-1:0] hash_start;

	modport source (output valid, output hash_start, input ready);
	modport sink (input valid, input hash_start, output ready);
endinterface

[hw/rtl/lgp_core.sv]
module lgp_core import lgp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lgp_in_if.sink    text,
	lgp_cfg_if.sink   cfg,
	input  logic      space_ok,
	output push_t     push
);

	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;
	logic       fire;

	logic [HASH_BITS-1:0]   hash_start_q, hash_q, hash_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [OFFSET_BITS-1:0] start_q, start_d;
	logic [OFFSET_BITS-1:0] len_q, len_d;
	logic                   content_q, content_d;
	logic                   acr_q, acr_d;
	logic [GROUP_BITS-1:0]  gc_q, gc_d;

	logic [GROUP_BITS-1:0]  gc_after;
	res_t                   line_res, grp_res, done_res;
	res_t [MAX_RESULTS-1:0] item;
	logic [NUM_BITS-1:0]    n;
	logic                   close;

	assign text.ready = !valid_s1 || space_ok;
	assign fire       = valid_s1 && space_ok;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			cmd_s1  <= text.cmd;
			byte_s1 <= text.data_byte;
		end
	end

	always_comb begin
		gc_after = content_q ? sat_grp(gc_q) : gc_q;

		line_res             = '0;
		line_res.kind        = KIND_NAME;
		line_res.line_start  = start_q;
		line_res.line_length = len_q;

		grp_res            = '0;
		grp_res.kind       = KIND_GROUP;
		grp_res.group_size = gc_after;

		done_res            = '0;
		done_res.kind       = KIND_DONE;
		done_res.text_hash  = hash_q;
		done_res.byte_total = pos_q;

		hash_d    = hash_q;
		pos_d     = pos_q;
		start_d   = start_q;
		len_d     = len_q;
		content_d = content_q;
		acr_d     = acr_q;
		gc_d      = gc_q;
		item      = '0;
		n         = '0;
		close     = 1'b0;

		if (cmd_s1 == CMD_END) begin
			if (content_q) begin
				item[n] = line_res;
				n       = n + 1'b1;
			end
			if (gc_after != '0) begin
				item[n] = grp_res;
				n       = n + 1'b1;
			end
			item[n]   = done_res;
			n         = n + 1'b1;
			hash_d    = hash_start_q;
			pos_d     = '0;
			start_d   = '0;
			len_d     = '0;
			content_d = 1'b0;
			acr_d     = 1'b0;
			gc_d      = '0;
		end else begin
			hash_d = HASH_BITS'((hash_q ^ {{(HASH_BITS-8){1'b0}}, byte_s1}) * FNV_PRIME);
			pos_d  = sat_off(pos_q);
			case (byte_s1)
				CHAR_CR: begin
					close = 1'b1;
					acr_d = 1'b1;
				end
				CHAR_LF: begin
					// The LF of a CR LF pair ends no line of its own.
					if (acr_q) begin
						acr_d = 1'b0;
					end else begin
						close = 1'b1;
					end
				end
				default: begin
					acr_d = 1'b0;
					if (len_q == '0) begin
						start_d = pos_q;
					end
					len_d = sat_off(len_q);
					if (!is_blank(byte_s1)) begin
						content_d = 1'b1;
					end
				end
			endcase
			if (close) begin
				if (content_q) begin
					item[n] = line_res;
					n       = n + 1'b1;
					gc_d    = gc_after;
				end else if (gc_q != '0) begin
					item[n] = grp_res;
					n       = n + 1'b1;
					gc_d    = '0;
				end
				len_d     = '0;
				start_d   = '0;
				content_d = 1'b0;
			end
		end

		if (n != '0) begin
			item[n - 1'b1].run_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_start_q <= FNV_START;
			hash_q       <= FNV_START;
			pos_q        <= '0;
			start_q      <= '0;
			len_q        <= '0;
			content_q    <= 1'b0;
			acr_q        <= 1'b0;
			gc_q         <= '0;
		end else begin
			if (fire) begin
				pos_q     <= pos_d;
				start_q   <= start_d;
				len_q     <= len_d;
				content_q <= content_d;
				acr_q     <= acr_d;
				gc_q      <= gc_d;
			end
			if (cfg.valid && cfg.ready) begin
				hash_start_q <= cfg.hash_start;
			end
			// Before the first byte of a text the running hash follows the register.
			if (cfg.valid && cfg.ready && pos_q == '0) begin
				hash_q <= cfg.hash_start;
			end else if (fire) begin
				hash_q <= hash_d;
			end
		end
	end

	assign push.num  = fire ? n : '0;
	assign push.item = item;

endmodule

[hw/rtl/lgp_result_queue.sv]
module lgp_result_queue import lgp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  push_t     push,
	output logic      space_ok,
	lgp_out_if.source result
);

	res_t                 mem [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 pop;
	res_t                 head;

	// Room for a full set of results from one request.
	assign space_ok = (count_q <= QCNT_BITS'(QDEPTH - MAX_RESULTS));
	assign pop      = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_BITS'(push.num);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_BITS'(push.num) - QCNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (NUM_BITS'(i) < push.num) begin
				mem[wr_ptr_q + QPTR_BITS'(i)] <= push.item[i];
			end
		end
	end

	assign head               = mem[rd_ptr_q];
	assign result.valid       = (count_q != '0);
	assign result.kind        = head.kind;
	assign result.line_start  = head.line_start;
	assign result.line_length = head.line_length;
	assign result.group_size  = head.group_size;
	assign result.text_hash   = head.text_hash;
	assign result.byte_total  = head.byte_total;
	assign result.run_last    = head.run_last;

endmodule

[hw/rtl/line_group_parser_with_hash.sv]
// Line group parser with FNV-1a 32 hash.
// The text channel takes one request per byte (cmd 0) and one end marker (cmd 1).
// The cfg channel loads hash_start; it is always ready, and it is to be written
// by the user only while idle, which the block itself does not enforce.
// The result channel gives name lines (kind 0), closed groups (kind 1) and the
// final hash and byte count (kind 2); run_last marks the last result of a request.
// A request is held in the input register, where its results are formed and
// written into a four-entry result queue once the queue has room.
// Text bytes are taken at one per cycle while the queue has room. A byte gives
// at most one result; an end marker gives up to three, which leave the queue one
// per cycle while the receiver is ready, and the request after it waits in the
// input register until the queue has room again.
// The input register moves on while the queue holds at most one result, so a
// stalled receiver stops the text channel once the queue holds more.
// Reset clears the parser state and the queue and sets hash_start to 0x811C9DC5.
// After each end marker the parser returns to that state, keeping hash_start.
module line_group_parser_with_hash import lgp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lgp_in_if.sink    text,
	lgp_cfg_if.sink   cfg,
	lgp_out_if.source result
);

	push_t push;
	logic  space_ok;

	lgp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.cfg      (cfg),
		.space_ok (space_ok),
		.push     (push)
	);

	lgp_result_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.result   (result)
	);

endmodule

[tb/line_group_parser_with_hash_tb.sv]
module line_group_parser_with_hash_tb import lgp_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES       = 5;
	localparam int PHASE_ITEMS  = 30;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = 8;
	localparam int LIMIT_CYCLES = 2_000_000;

	// Predicts the reports of the parser for each accepted request and
	// checks the reports coming out of the block in order.
	class parse_checker;
		logic [HASH_BITS-1:0]   start_reg;
		logic [HASH_BITS-1:0]   hash_acc;
		logic [OFFSET_BITS-1:0] pos;
		logic [OFFSET_BITS-1:0] ln_start;
		logic [OFFSET_BITS-1:0] ln_len;
		logic [GROUP_BITS-1:0]  members;
		bit                     has_name;
		bit                     saw_cr;
		res_t                   fresh[$];
		res_t                   pending_reports[$];
		int unsigned            fail_count;
		int unsigned            shown;
		int unsigned            kind_seen[3];

		function new();
			start_reg = FNV_START;
			clear_text();
		endfunction

		function void clear_text();
			hash_acc = start_reg;
			pos      = '0;
			ln_start = '0;
			ln_len   = '0;
			members  = '0;
			has_name = 1'b0;
			saw_cr   = 1'b0;
		endfunction

		function void load_hash_start(logic [HASH_BITS-1:0] v);
			start_reg = v;
			if (pos == '0)
				hash_acc = v;
		endfunction

		function logic [OFFSET_BITS-1:0] bump_off(logic [OFFSET_BITS-1:0] v);
			return (&v) ? v : v + 1'b1;
		endfunction

		function void add_report(kind_t k, logic [OFFSET_BITS-1:0] ls,
				logic [OFFSET_BITS-1:0] ll, logic [GROUP_BITS-1:0] gs,
				logic [HASH_BITS-1:0] th, logic [OFFSET_BITS-1:0] bt);
			res_t r;
			r = '0;
			r.kind        = k;
			r.line_start  = ls;
			r.line_length = ll;
			r.group_size  = gs;
			r.text_hash   = th;
			r.byte_total  = bt;
			fresh = {fresh, r};
		endfunction

		function void close_group();
			if (members != '0) begin
				add_report(KIND_GROUP, '0, '0, members, '0, '0);
				members = '0;
			end
		endfunction

		function void close_line();
			if (has_name) begin
				add_report(KIND_NAME, ln_start, ln_len, '0, '0, '0);
				members = (&members) ? members : members + 1'b1;
			end else begin
				close_group();
			end
			ln_start = '0;
			ln_len   = '0;
			has_name = 1'b0;
		endfunction

		function void note_request(logic cmd, logic [7:0] b);
			logic [OFFSET_BITS-1:0] here;
			fresh.delete();
			if (cmd == CMD_END) begin
				close_line();
				close_group();
				add_report(KIND_DONE, '0, '0, '0, hash_acc, pos);
				clear_text();
			end else begin
				here     = pos;
				hash_acc = (hash_acc ^ {24'b0, b}) * FNV_PRIME;
				pos      = bump_off(pos);
				if (b == CHAR_CR) begin
					close_line();
					saw_cr = 1'b1;
				end else if (b == CHAR_LF) begin
					// The LF of a CR LF pair ends no second line.
					if (saw_cr)
						saw_cr = 1'b0;
					else
						close_line();
				end else begin
					saw_cr = 1'b0;
					if (ln_len == '0)
						ln_start = here;
					ln_len = bump_off(ln_len);
					if (b != CHAR_SPACE && b != CHAR_TAB)
						has_name = 1'b1;
				end
			end
			if (fresh.size() > 0)
				fresh[fresh.size()-1].run_last = 1'b1;
			foreach (fresh[i])
				pending_reports = {pending_reports, fresh[i]};
		endfunction

		function void note_failure(string msg);
			fail_count++;
			if (shown < 10) begin
				shown++;
				$display("ERROR: %s", msg);
			end
		endfunction

		function void check_report(res_t got);
			res_t want;
			if (pending_reports.size() == 0) begin
				note_failure($sformatf("unexpected report kind %0d start %0d len %0d",
					got.kind, got.line_start, got.line_length));
				return;
			end
			want = pending_reports.pop_front();
			if (got.kind <= KIND_DONE)
				kind_seen[got.kind]++;
			if (got.kind !== want.kind || got.line_start !== want.line_start ||
					got.line_length !== want.line_length ||
					got.group_size !== want.group_size ||
					got.text_hash !== want.text_hash ||
					got.byte_total !== want.byte_total ||
					got.run_last !== want.run_last)
				note_failure($sformatf({"report mismatch: expected kind %0d start %0d len %0d ",
					"group %0d hash %h bytes %0d last %0d, got kind %0d start %0d len %0d ",
					"group %0d hash %h bytes %0d last %0d"},
					want.kind, want.line_start, want.line_length, want.group_size,
					want.text_hash, want.byte_total, want.run_last,
					got.kind, got.line_start, got.line_length, got.group_size,
					got.text_hash, got.byte_total, got.run_last));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lgp_in_if  text_if ();
	lgp_cfg_if cfg_if ();
	lgp_out_if res_if ();

	line_group_parser_with_hash DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.cfg    (cfg_if),
		.result (res_if)
	);

	parse_checker sb = new();

	bit          sender_gaps   = 1'b1;
	bit          receiver_gaps = 1'b1;
	bit          hold_req      = 1'b0;
	int unsigned items_sent    = 0;
	int unsigned cfg_writes    = 0;
	int unsigned cycle_count   = 0;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Timed out after %0d cycles.", cycle_count);
			$display("line_group_parser_with_hash_tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin : result_watch
		res_t got;
		if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			got.kind        = kind_t'(res_if.kind);
			got.line_start  = res_if.line_start;
			got.line_length = res_if.line_length;
			got.group_size  = res_if.group_size;
			got.text_hash   = res_if.text_hash;
			got.byte_total  = res_if.byte_total;
			got.run_last    = res_if.run_last;
			sb.check_report(got);
		end
	end

	// Receiver side: random stalls, plus one long hold on request.
	initial begin
		res_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
				res_if.ready <= 1'b1;
			end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				res_if.ready <= 1'b1;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	function automatic logic [7:0] text_byte();
		case ($urandom_range(0, 3))
			0: return CHAR_SPACE;
			1: return CHAR_TAB;
			2: return 8'($urandom_range(8'h21, 8'h7E));
			default: return 8'($urandom_range(8'h80, 8'hFF));
		endcase
	endfunction

	task automatic send_item(input logic c, input logic [7:0] b);
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			text_if.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		text_if.valid     <= 1'b1;
		text_if.cmd       <= c;
		text_if.data_byte <= b;
		do @(posedge clk); while (text_if.ready !== 1'b1);
		sb.note_request(c, b);
		items_sent++;
	endtask

	task automatic send_line_end();
		case ($urandom_range(0, 3))
			0: send_item(CMD_BYTE, CHAR_CR);
			1: send_item(CMD_BYTE, CHAR_LF);
			2: begin
				send_item(CMD_BYTE, CHAR_CR);
				send_item(CMD_BYTE, CHAR_LF);
			end
			default: begin
				send_item(CMD_BYTE, CHAR_LF);
				send_item(CMD_BYTE, CHAR_CR);
			end
		endcase
	endtask

	// Mostly well-formed lines: names with blanks mixed in, blank lines,
	// and now and then a line of arbitrary bytes.
	task automatic send_random_text(input bit closed);
		int pick;
		int len;
		int key;
		repeat ($urandom_range(1, 6)) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				len = $urandom_range(1, 8);
				key = $urandom_range(0, len - 1);
				for (int i = 0; i < len; i++)
					send_item(CMD_BYTE, (i == key) ? 8'($urandom_range(8'h21, 8'h7E))
						: text_byte());
			end else if (pick < 9) begin
				repeat ($urandom_range(0, 3))
					send_item(CMD_BYTE, ($urandom_range(0, 1) == 0) ? CHAR_SPACE : CHAR_TAB);
			end else begin
				repeat ($urandom_range(1, 6))
					send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
			end
			send_line_end();
		end
		if (closed)
			send_item(CMD_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic wait_idle();
		text_if.valid <= 1'b0;
		while (sb.pending_reports.size() != 0 || hold_req)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [HASH_BITS-1:0] v);
		cfg_if.valid      <= 1'b1;
		cfg_if.hash_start <= v;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		cfg_if.valid <= 1'b0;
		sb.load_hash_start(v);
		cfg_writes++;
	endtask

	initial begin
		logic [HASH_BITS-1:0] setting;
		int                   phase_start;

		arst_n            = 1'b0;
		text_if.valid     = 1'b0;
		text_if.cmd       = CMD_BYTE;
		text_if.data_byte = 8'h00;
		cfg_if.valid      = 1'b0;
		cfg_if.hash_start = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed texts under the reset value of hash_start: CR LF pair,
		// blank and empty lines, repeated blanks, byte extremes, an empty
		// text and a text whose last line is closed by the end marker.
		send_item(CMD_BYTE, 8'h61);
		send_item(CMD_BYTE, 8'h62);
		send_item(CMD_BYTE, CHAR_CR);
		send_item(CMD_BYTE, CHAR_LF);
		send_item(CMD_BYTE, CHAR_SPACE);
		send_item(CMD_BYTE, CHAR_TAB);
		send_item(CMD_BYTE, CHAR_LF);
		send_item(CMD_BYTE, CHAR_LF);
		send_item(CMD_BYTE, 8'h00);
		send_item(CMD_BYTE, 8'hFF);
		send_item(CMD_BYTE, CHAR_CR);
		send_item(CMD_BYTE, CHAR_CR);
		send_item(CMD_END, 8'h00);
		send_item(CMD_END, 8'hFF);
		send_item(CMD_BYTE, CHAR_TAB);
		send_item(CMD_BYTE, 8'h7A);
		send_item(CMD_BYTE, CHAR_LF);
		send_item(CMD_BYTE, 8'h71);
		send_item(CMD_END, 8'h55);

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: setting = '0;
				1: setting = '1;
				2: setting = FNV_START;
				default: setting = $urandom;
			endcase
			cfg_write(setting);
			if (phase == 2)
				hold_req = 1'b1;
			if (phase == PHASES - 1) begin
				sender_gaps   = 1'b0;
				receiver_gaps = 1'b0;
			end
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS)
				send_random_text($urandom_range(0, 3) != 0);
			// Leave a text open so the next register load lands mid-text.
			if (phase % 2 == 1) begin
				send_item(CMD_BYTE, 8'h78);
				send_item(CMD_BYTE, 8'h79);
			end
		end

		send_item(CMD_END, 8'h00);

		wait_idle();
		$display("Sent %0d requests and %0d hash_start loads; checked %0d name lines,",
			items_sent, cfg_writes, sb.kind_seen[KIND_NAME]);
		$display("%0d group closes and %0d text ends, with stalls and mid-text loads.",
			sb.kind_seen[KIND_GROUP], sb.kind_seen[KIND_DONE]);
		if (sb.fail_count == 0 && sb.pending_reports.size() == 0) begin
			$display("line_group_parser_with_hash_tb: PASS");
		end else begin
			$display("%0d failures, %0d reports still expected.",
				sb.fail_count, sb.pending_reports.size());
			$display("line_group_parser_with_hash_tb: FAIL");
		end
		$finish;
	end

endmodule
